[hw/rtl/max_pool_2d_defines.svh]
// Assertion macros for the max pooling RTL.
// Assertions compile away when SYNTH is defined.
`ifndef MAX_POOL_2D_DEFINES_SVH
`define MAX_POOL_2D_DEFINES_SVH
`ifndef SYNTH
`define MP2D_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: check failed");
`define MP2D_ASSERT_NEXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("%m: check failed");
`else
`define MP2D_ASSERT(lbl, clk, rst, prop)
`define MP2D_ASSERT_NEXT(lbl, clk, rst, pre, post)
`endif
`endif

[hw/rtl/mp2d_pkg.sv]
// Types and constants for the max pooling block.
// Used by every module of the block; depends on nothing.
package mp2d_pkg;

   localparam int SampleBits    = 16;
   localparam int RowBits       = 12;
   localparam int ColBits       = 8;
   localparam int PosBits       = 12;
   localparam int TileCntBits   = 4;
   localparam int TileBits      = 5;
   localparam int DimBits       = 13;
   localparam int OutColBits    = 9;
   localparam int OutRowBits    = 13;
   localparam int CsrIdxBits    = 3;
   localparam int CsrBits       = 13;
   localparam int TileMax       = 16;
   localparam int DimMax        = 4096;
   localparam int StoreDepthMax = 256;
   localparam int DefMaxOutCols = 256;

   typedef enum logic [CsrIdxBits-1:0] {
      CSR_TILE_ROWS = 3'd0,
      CSR_TILE_COLS = 3'd1,
      CSR_IN_COLS   = 3'd2,
      CSR_IN_ROWS   = 3'd3,
      CSR_OUT_COLS  = 3'd4,
      CSR_OUT_ROWS  = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic signed [SampleBits-1:0] sample;
      logic                         plane_start;
   } req_data_type;

   typedef struct packed {
      logic signed [SampleBits-1:0] pooled_value;
      logic [RowBits-1:0]           out_row;
      logic [ColBits-1:0]           out_col;
      logic                         plane_last;
   } rsp_data_type;

   // Clamped register values as the datapath uses them; or_lim is raw.
   typedef struct packed {
      logic [TileBits-1:0]   tr;
      logic [TileBits-1:0]   tc;
      logic [DimBits-1:0]    ic;
      logic [DimBits-1:0]    ir;
      logic [OutColBits-1:0] oc_lim;
      logic [OutRowBits-1:0] or_lim;
   } cfg_type;

   // One line store operation, issued on the last column of a tile row.
   typedef struct packed {
      logic                         valid;
      logic                         emit;
      logic                         use_store;
      logic signed [SampleBits-1:0] rm;
      logic [RowBits-1:0]           row;
      logic [ColBits-1:0]           col;
      logic                         last;
   } op_type;

endpackage

[hw/rtl/mp2d_cfg.sv]
// Configuration registers of the max pooling block, with range clamping.
// Depends on mp2d_pkg.
module mp2d_cfg import mp2d_pkg::*; #(
   parameter int MAX_OUT_COLS = DefMaxOutCols
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CsrIdxBits-1:0] csr_index,
   input  logic [CsrBits-1:0]    csr_wdata,
   output cfg_type               cfg
);

   localparam int ColLimit = (MAX_OUT_COLS < StoreDepthMax) ? MAX_OUT_COLS : StoreDepthMax;

   logic [TileBits-1:0]   tile_rows_ff, tile_cols_ff;
   logic [DimBits-1:0]    in_cols_ff, in_rows_ff;
   logic [OutColBits-1:0] out_cols_ff;
   logic [OutRowBits-1:0] out_rows_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tile_rows_ff <= TileBits'(2);
         tile_cols_ff <= TileBits'(2);
         in_cols_ff   <= DimBits'(64);
         in_rows_ff   <= DimBits'(64);
         out_cols_ff  <= OutColBits'(32);
         out_rows_ff  <= OutRowBits'(32);
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_TILE_ROWS: tile_rows_ff <= csr_wdata[TileBits-1:0];
            CSR_TILE_COLS: tile_cols_ff <= csr_wdata[TileBits-1:0];
            CSR_IN_COLS:   in_cols_ff   <= csr_wdata[DimBits-1:0];
            CSR_IN_ROWS:   in_rows_ff   <= csr_wdata[DimBits-1:0];
            CSR_OUT_COLS:  out_cols_ff  <= csr_wdata[OutColBits-1:0];
            CSR_OUT_ROWS:  out_rows_ff  <= csr_wdata[OutRowBits-1:0];
            default: ;
         endcase
      end
   end

   function automatic logic [TileBits-1:0] clamp_tile(input logic [TileBits-1:0] v);
      if (v == '0) return TileBits'(1);
      if (v > TileBits'(TileMax)) return TileBits'(TileMax);
      return v;
   endfunction

   function automatic logic [DimBits-1:0] clamp_dim(input logic [DimBits-1:0] v);
      if (v == '0) return DimBits'(1);
      if (v > DimBits'(DimMax)) return DimBits'(DimMax);
      return v;
   endfunction

   always_comb begin
      cfg.tr     = clamp_tile(tile_rows_ff);
      cfg.tc     = clamp_tile(tile_cols_ff);
      cfg.ic     = clamp_dim(in_cols_ff);
      cfg.ir     = clamp_dim(in_rows_ff);
      cfg.oc_lim = (out_cols_ff > OutColBits'(ColLimit)) ? OutColBits'(ColLimit) : out_cols_ff;
      cfg.or_lim = out_rows_ff;
   end

endmodule

[hw/rtl/mp2d_seq.sv]
// Raster position and tile counters of the max pooling block.
// Builds one line store operation per tile row; depends on mp2d_pkg.
module mp2d_seq import mp2d_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  logic         accept,
   input  req_data_type req_data,
   output op_type       op
);

   logic [PosBits-1:0]     col_pos_ff, col_pos_in, row_pos_ff, row_pos_in;
   logic [TileCntBits-1:0] cit_ff, cit_in, rit_ff, rit_in;
   logic [OutColBits-1:0]  ocol_ff, ocol_in;
   logic [OutRowBits-1:0]  orow_ff, orow_in;
   logic signed [SampleBits-1:0] rm_ff, rm_in;

   logic [PosBits-1:0]     col_pos_e, row_pos_e;
   logic [TileCntBits-1:0] cit_e, rit_e;
   logic [OutColBits-1:0]  ocol_e;
   logic [OutRowBits-1:0]  orow_e;
   logic [14:0]            col_end, col_end2;
   logic [18:0]            row_end, row_end2;
   logic                   row_ok, col_ok, active, last_col, last_row;
   logic                   row_final, col_final;
   logic [DimBits-1:0]     col_next, row_next;
   logic signed [SampleBits-1:0] smp;

   // A plane start clears the position counters before the sample is taken.
   always_comb begin
      smp       = req_data.sample;
      col_pos_e = req_data.plane_start ? '0 : col_pos_ff;
      row_pos_e = req_data.plane_start ? '0 : row_pos_ff;
      cit_e     = req_data.plane_start ? '0 : cit_ff;
      rit_e     = req_data.plane_start ? '0 : rit_ff;
      ocol_e    = req_data.plane_start ? '0 : ocol_ff;
      orow_e    = req_data.plane_start ? '0 : orow_ff;
   end

   // A tile column exists while inside the row and the column limit; avoids a divider.
   always_comb begin
      col_end   = (15'(ocol_e) + 15'd1) * 15'(cfg.tc);
      col_end2  = (15'(ocol_e) + 15'd2) * 15'(cfg.tc);
      row_end   = (19'(orow_e) + 19'd1) * 19'(cfg.tr);
      row_end2  = (19'(orow_e) + 19'd2) * 19'(cfg.tr);
      col_ok    = (ocol_e < cfg.oc_lim) && (col_end <= 15'(cfg.ic));
      row_ok    = (orow_e < cfg.or_lim) && (row_end <= 19'(cfg.ir));
      col_final = ((10'(ocol_e) + 10'd1) >= 10'(cfg.oc_lim)) || (col_end2 > 15'(cfg.ic));
      row_final = ((14'(orow_e) + 14'd1) >= 14'(cfg.or_lim)) || (row_end2 > 19'(cfg.ir));
      active    = row_ok && col_ok;
      last_col  = (TileBits'(cit_e) + TileBits'(1)) >= cfg.tc;
      last_row  = (TileBits'(rit_e) + TileBits'(1)) >= cfg.tr;
      col_next  = DimBits'(col_pos_e) + DimBits'(1);
      row_next  = DimBits'(row_pos_e) + DimBits'(1);
   end

   always_comb begin
      col_pos_in = col_pos_ff;
      row_pos_in = row_pos_ff;
      cit_in     = cit_ff;
      rit_in     = rit_ff;
      ocol_in    = ocol_ff;
      orow_in    = orow_ff;
      rm_in      = rm_ff;
      if (accept) begin
         col_pos_in = col_pos_e;
         row_pos_in = row_pos_e;
         cit_in     = cit_e;
         rit_in     = rit_e;
         ocol_in    = ocol_e;
         orow_in    = orow_e;
         if (active) begin
            if (cit_e == '0 || smp > rm_ff) begin
               rm_in = smp;
            end
            if (last_col) begin
               cit_in  = '0;
               ocol_in = ocol_e + OutColBits'(1);
            end else begin
               cit_in = cit_e + TileCntBits'(1);
            end
         end
         if (col_next >= cfg.ic) begin
            col_pos_in = '0;
            cit_in     = '0;
            ocol_in    = '0;
            if (row_next >= cfg.ir) begin
               row_pos_in = '0;
               rit_in     = '0;
               orow_in    = '0;
            end else begin
               row_pos_in = row_next[PosBits-1:0];
               if (row_ok) begin
                  if (last_row) begin
                     rit_in  = '0;
                     orow_in = orow_e + OutRowBits'(1);
                  end else begin
                     rit_in = rit_e + TileCntBits'(1);
                  end
               end
            end
         end else begin
            col_pos_in = col_next[PosBits-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_pos_ff <= '0;
         row_pos_ff <= '0;
         cit_ff     <= '0;
         rit_ff     <= '0;
         ocol_ff    <= '0;
         orow_ff    <= '0;
         rm_ff      <= '0;
      end else begin
         col_pos_ff <= col_pos_in;
         row_pos_ff <= row_pos_in;
         cit_ff     <= cit_in;
         rit_ff     <= rit_in;
         ocol_ff    <= ocol_in;
         orow_ff    <= orow_in;
         rm_ff      <= rm_in;
      end
   end

   always_comb begin
      op.valid     = accept && active && last_col;
      op.emit      = last_row;
      op.use_store = (rit_e != '0);
      op.rm        = rm_in;
      op.row       = orow_e[RowBits-1:0];
      op.col       = ocol_e[ColBits-1:0];
      op.last      = row_final && col_final;
   end

endmodule

[hw/rtl/mp2d_line.sv]
// Column line store with read-modify-write, forwarding and the result register.
// Depends on mp2d_pkg and max_pool_2d_defines.svh.
`include "max_pool_2d_defines.svh"
module mp2d_line import mp2d_pkg::*; #(
   parameter int MAX_OUT_COLS = DefMaxOutCols
) (
   input  logic         clock,
   input  logic         reset,
   input  op_type       op,
   output logic         req_stall,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_data_type rsp_data
);

   localparam int Depth = (MAX_OUT_COLS < StoreDepthMax) ? MAX_OUT_COLS : StoreDepthMax;
   localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;

   logic signed [SampleBits-1:0] mem [Depth];
   logic signed [SampleBits-1:0] rd_ff, fwd_data_ff, stored, m;
   logic                         fwd_flag_ff;
   op_type                       s1_ff;
   logic                         rsp_valid_ff;
   rsp_data_type                 rsp_data_ff;
   logic                         advance, wr_en, rsp_load;

   // Only a tile result that cannot leave holds the pipeline; store updates always move.
   always_comb begin
      advance  = !(s1_ff.valid && s1_ff.emit && rsp_valid_ff && rsp_stall);
      wr_en    = s1_ff.valid && !s1_ff.emit && advance;
      rsp_load = s1_ff.valid && s1_ff.emit && advance;
      stored   = fwd_flag_ff ? fwd_data_ff : rd_ff;
      m        = (s1_ff.use_store && stored > s1_ff.rm) ? stored : s1_ff.rm;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[s1_ff.col[AW-1:0]] <= m;
      end
   end

   always_ff @(posedge clock) begin
      if (op.valid) begin
         rd_ff <= mem[op.col[AW-1:0]];
      end
   end

   // A write to the entry being read in the same cycle is forwarded past the memory.
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_flag_ff <= 1'b0;
      end else if (op.valid) begin
         fwd_flag_ff <= wr_en && (s1_ff.col[AW-1:0] == op.col[AW-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (op.valid) begin
         fwd_data_ff <= m;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= '0;
      end else if (advance) begin
         s1_ff <= op;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff.pooled_value <= m;
         rsp_data_ff.out_row      <= s1_ff.row;
         rsp_data_ff.out_col      <= s1_ff.col;
         rsp_data_ff.plane_last   <= s1_ff.last;
      end
   end

   assign req_stall = !advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `MP2D_ASSERT_NEXT(a_s1_hold, clock, reset, s1_ff.valid && !advance, $stable(s1_ff))
   `MP2D_ASSERT(a_wr_xor_out, clock, reset, !(wr_en && rsp_load))
   `MP2D_ASSERT(a_upd_no_stall, clock, reset, (s1_ff.valid && !s1_ff.emit) |-> advance)

endmodule

[hw/rtl/max_pool_2d.sv]
// Non-overlapping 2D max pooling over signed Q8.8 samples in raster order. The block
// takes one sample per clock unless stalled and returns each tile maximum through its
// operation and result registers. A line store of one entry per output column keeps
// the partial maximum between tile rows; it is read when a tile row ends and written
// back in the next cycle, with a bypass when a read hits that column. The input is
// stalled only while a tile result waits on a stalled output with another behind it.
// Samples outside whole tiles are dropped. Registers may be written only while idle.
module max_pool_2d import mp2d_pkg::*; #(
   parameter int MAX_OUT_COLS = DefMaxOutCols
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_data_type          req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_data_type          rsp_data,
   input  logic                  csr_we,
   input  logic [CsrIdxBits-1:0] csr_index,
   input  logic [CsrBits-1:0]    csr_wdata
);

   cfg_type cfg;
   op_type  op;
   logic    accept;

   assign accept = req_valid && !req_stall;

   mp2d_cfg #(
      .MAX_OUT_COLS (MAX_OUT_COLS)
   ) u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   mp2d_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .accept   (accept),
      .req_data (req_data),
      .op       (op)
   );

   mp2d_line #(
      .MAX_OUT_COLS (MAX_OUT_COLS)
   ) u_line (
      .clock     (clock),
      .reset     (reset),
      .op        (op),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
